// ===== rtl/assert_macros.svh =====
// Assertion macros used by the RTL controller module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_NOW(lbl, clk, rst, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== rtl/ems2cal_pkg.sv =====
// Types, command codes and calendar constants for the epoch-to-calendar converter.
package ems2cal_pkg;

  localparam int LEN_W = 36;

  localparam logic [LEN_W-1:0] MS_PER_MIN  = LEN_W'(60000);
  localparam logic [LEN_W-1:0] MS_PER_HOUR = LEN_W'(3600000);
  localparam logic [LEN_W-1:0] MS_PER_DAY  = LEN_W'(1000 * 60 * 60 * 24);
  localparam logic [LEN_W-1:0] MS_PER_YEAR = LEN_W'(64'd86400000 * 64'd365);
  localparam logic [LEN_W-1:0] MS_PER_LEAP = LEN_W'(64'd86400000 * 64'd366);

  localparam logic [11:0] EPOCH_YEAR   = 12'd1970;
  localparam logic [6:0]  EPOCH_MOD100 = 7'd70;
  localparam logic [8:0]  EPOCH_MOD400 = 9'd370;

  localparam logic [2:0] OP_NONE  = 3'd0;
  localparam logic [2:0] OP_LOAD  = 3'd1;
  localparam logic [2:0] OP_YEAR  = 3'd2;
  localparam logic [2:0] OP_MONTH = 3'd3;
  localparam logic [2:0] OP_DAY   = 3'd4;
  localparam logic [2:0] OP_HOUR  = 3'd5;
  localparam logic [2:0] OP_MIN   = 3'd6;
  localparam logic [2:0] OP_STORE = 3'd7;

  typedef struct packed {
    logic [2:0] op;
    logic [2:0] bit_idx;
  } cmd_t;

  typedef struct packed {
    logic ge;
    logic month_end;
  } sts_t;

  function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
    logic [4:0] d;
    case (m)
      4'd2: d = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
      default: d = 5'd31;
    endcase
    return d;
  endfunction

endpackage

// ===== rtl/ems2cal_dp.sv =====
// Datapath: remainder, calendar counters, shared subtractor and result registers.
module ems2cal_dp #(
  parameter int STAMP_BITS = 42
) (
  input  logic                  clk,
  input  logic [STAMP_BITS-1:0] epoch_millis,
  input  ems2cal_pkg::cmd_t     cmd,
  output ems2cal_pkg::sts_t     sts,
  output logic [11:0]           cal_year,
  output logic [3:0]            cal_month,
  output logic [4:0]            cal_day,
  output logic [4:0]            hour_of_day,
  output logic [5:0]            minute_of_hour
);

  localparam int CW = ((STAMP_BITS > ems2cal_pkg::LEN_W) ? STAMP_BITS
                                                          : ems2cal_pkg::LEN_W) + 1;

  logic [STAMP_BITS-1:0]         rest;
  logic [11:0]                   year;
  logic [6:0]                    mod100;
  logic [8:0]                    mod400;
  logic [3:0]                    month;
  logic [4:0]                    day_q;
  logic [4:0]                    hour_q;
  logic [5:0]                    min_q;
  logic                          leap;
  logic [ems2cal_pkg::LEN_W-1:0] sub;
  logic [CW-1:0]                 diff;

  assign leap = (year[1:0] == 2'd0) && ((mod100 != 7'd0) || (mod400 == 9'd0));

  always_comb begin
    case (cmd.op)
      ems2cal_pkg::OP_YEAR:
        sub = leap ? ems2cal_pkg::MS_PER_LEAP : ems2cal_pkg::MS_PER_YEAR;
      ems2cal_pkg::OP_MONTH:
        sub = ems2cal_pkg::LEN_W'(ems2cal_pkg::month_days(month, leap)
              * ems2cal_pkg::MS_PER_DAY);
      ems2cal_pkg::OP_DAY:  sub = ems2cal_pkg::MS_PER_DAY << cmd.bit_idx;
      ems2cal_pkg::OP_HOUR: sub = ems2cal_pkg::MS_PER_HOUR << cmd.bit_idx;
      ems2cal_pkg::OP_MIN:  sub = ems2cal_pkg::MS_PER_MIN << cmd.bit_idx;
      default:              sub = '0;
    endcase
  end

  assign diff          = CW'(rest) - CW'(sub);
  assign sts.ge        = !diff[CW-1];
  assign sts.month_end = (month == 4'd12);

  always_ff @(posedge clk) begin
    case (cmd.op)
      ems2cal_pkg::OP_LOAD: begin
        rest   <= epoch_millis;
        year   <= ems2cal_pkg::EPOCH_YEAR;
        mod100 <= ems2cal_pkg::EPOCH_MOD100;
        mod400 <= ems2cal_pkg::EPOCH_MOD400;
        month  <= 4'd1;
        day_q  <= '0;
        hour_q <= '0;
        min_q  <= '0;
      end
      ems2cal_pkg::OP_YEAR: begin
        if (sts.ge) begin
          rest   <= diff[STAMP_BITS-1:0];
          year   <= year + 12'd1;
          mod100 <= (mod100 == 7'd99) ? 7'd0 : mod100 + 7'd1;
          mod400 <= (mod400 == 9'd399) ? 9'd0 : mod400 + 9'd1;
        end
      end
      ems2cal_pkg::OP_MONTH: begin
        if (sts.ge && !sts.month_end) begin
          rest  <= diff[STAMP_BITS-1:0];
          month <= month + 4'd1;
        end
      end
      ems2cal_pkg::OP_DAY: begin
        if (sts.ge) begin
          rest                 <= diff[STAMP_BITS-1:0];
          day_q[cmd.bit_idx]   <= 1'b1;
        end
      end
      ems2cal_pkg::OP_HOUR: begin
        if (sts.ge) begin
          rest                 <= diff[STAMP_BITS-1:0];
          hour_q[cmd.bit_idx]  <= 1'b1;
        end
      end
      ems2cal_pkg::OP_MIN: begin
        if (sts.ge) begin
          rest                 <= diff[STAMP_BITS-1:0];
          min_q[cmd.bit_idx]   <= 1'b1;
        end
      end
      ems2cal_pkg::OP_STORE: begin
        cal_year       <= year;
        cal_month      <= month;
        cal_day        <= day_q + 5'd1;
        hour_of_day    <= hour_q;
        minute_of_hour <= min_q;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== rtl/ems2cal_ctrl.sv =====
// Controller: sequences year, month and digit steps and owns both handshakes.
`include "assert_macros.svh"

module ems2cal_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  ems2cal_pkg::sts_t sts,
  output ems2cal_pkg::cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_YEAR  = 3'd1;
  localparam logic [2:0] S_MONTH = 3'd2;
  localparam logic [2:0] S_DAY   = 3'd3;
  localparam logic [2:0] S_HOUR  = 3'd4;
  localparam logic [2:0] S_MIN   = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic [2:0] bit_idx;
  logic [2:0] bit_idx_next;
  logic       store;

  assign in_stall    = (state != S_IDLE);
  assign store       = (state == S_FIN) && (!out_valid || !out_stall);

  always_comb begin
    state_next   = state;
    bit_idx_next = bit_idx;
    cmd.op       = ems2cal_pkg::OP_NONE;
    cmd.bit_idx  = bit_idx;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = ems2cal_pkg::OP_LOAD;
          state_next = S_YEAR;
        end
      end
      S_YEAR: begin
        cmd.op = ems2cal_pkg::OP_YEAR;
        if (!sts.ge) begin
          state_next = S_MONTH;
        end
      end
      S_MONTH: begin
        cmd.op = ems2cal_pkg::OP_MONTH;
        if (!sts.ge || sts.month_end) begin
          state_next   = S_DAY;
          bit_idx_next = 3'd4;
        end
      end
      S_DAY: begin
        cmd.op       = ems2cal_pkg::OP_DAY;
        bit_idx_next = bit_idx - 3'd1;
        if (bit_idx == 3'd0) begin
          state_next   = S_HOUR;
          bit_idx_next = 3'd4;
        end
      end
      S_HOUR: begin
        cmd.op       = ems2cal_pkg::OP_HOUR;
        bit_idx_next = bit_idx - 3'd1;
        if (bit_idx == 3'd0) begin
          state_next   = S_MIN;
          bit_idx_next = 3'd5;
        end
      end
      S_MIN: begin
        cmd.op       = ems2cal_pkg::OP_MIN;
        bit_idx_next = bit_idx - 3'd1;
        if (bit_idx == 3'd0) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (store) begin
          cmd.op     = ems2cal_pkg::OP_STORE;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      bit_idx   <= '0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      bit_idx <= bit_idx_next;
      if (store) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  `ASSERT_NEXT(a_load_starts, clk, rst, in_valid && !in_stall, state == S_YEAR, "request not started")
  `ASSERT_NEXT(a_hold_pending, clk, rst, state == S_FIN && out_valid && out_stall, state == S_FIN && out_valid, "pending result overwritten")
  `ASSERT_NOW(a_digit_range, clk, rst, state == S_DAY || state == S_HOUR, bit_idx <= 3'd4, "digit index out of range")
  `ASSERT_NEXT(a_store_valid, clk, rst, store, out_valid && state == S_IDLE, "store did not raise valid")

endmodule

// ===== rtl/epoch_ms_to_calendar.sv =====
// Top level: millisecond epoch count to Gregorian year, month, day, hour, minute.
//
//  channel  signals                        direction
//  in       in_valid, in_stall, epoch_millis   request in
//  out      out_valid, out_stall, cal_*, hour_of_day, minute_of_hour   result out
//
// A request is worked off by the shared subtractor: one year or month per cycle,
// then one quotient bit per cycle for day, hour and minute.
// Reset clears the controller; the result registers are not reset.
// A new request is taken while a finished result waits; the next result
// waits in the last step until the output register is free.
module epoch_ms_to_calendar #(
  parameter int STAMP_BITS = 42
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [STAMP_BITS-1:0] epoch_millis,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [11:0]           cal_year,
  output logic [3:0]            cal_month,
  output logic [4:0]            cal_day,
  output logic [4:0]            hour_of_day,
  output logic [5:0]            minute_of_hour
);

  ems2cal_pkg::cmd_t cmd;
  ems2cal_pkg::sts_t sts;

  ems2cal_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  ems2cal_dp #(
    .STAMP_BITS (STAMP_BITS)
  ) u_dp (
    .clk            (clk),
    .epoch_millis   (epoch_millis),
    .cmd            (cmd),
    .sts            (sts),
    .cal_year       (cal_year),
    .cal_month      (cal_month),
    .cal_day        (cal_day),
    .hour_of_day    (hour_of_day),
    .minute_of_hour (minute_of_hour)
  );

endmodule
